@@ src/ifmt_pkg.sv @@
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, constants and helper function of the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int unsigned WIDTH_MAX = 32;
  localparam int unsigned DIGIT_DEPTH = 11;
  localparam int unsigned PTR_DIGITS = 8;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_HEXL = 3'd2,
    CMD_HEXU = 3'd3,
    CMD_OCT  = 3'd4,
    CMD_PTR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } base_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_MUL,
    ST_DIV_STEP,
    ST_SETUP,
    ST_PREFIX,
    ST_LEAD,
    ST_DIGITS,
    ST_TRAIL
  } state_t;

  typedef enum logic [1:0] {
    SEL_PREFIX,
    SEL_LEAD,
    SEL_DIGIT,
    SEL_TRAIL
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      mul;
    logic      step;
    logic      push;
    emit_sel_t sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic in_base10;
    logic base10;
    logic step_last;
    logic has_prefix;
    logic prefix_end;
    logic lead_needed;
    logic trail_needed;
    logic pad_last;
    logic digit_end;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] letter_base;
    letter_base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'd0, d};
    end else begin
      digit_char = letter_base + {4'd0, d - 4'd10};
    end
  endfunction

endpackage

@@ src/ifmt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ifmt_ctrl
// Controller state machine: sequences digit extraction and character output.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  ifmt_pkg::ctrl_status_t status,
  output ifmt_pkg::ctrl_cmd_t    cmd,
  output ifmt_pkg::state_t       state
);

  ifmt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ifmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ifmt_pkg::ST_IDLE: begin
        if (s_tvalid && status.in_ok) begin
          state_next = status.in_base10 ? ifmt_pkg::ST_DIV_MUL : ifmt_pkg::ST_DIV_STEP;
        end
      end
      ifmt_pkg::ST_DIV_MUL: begin
        state_next = ifmt_pkg::ST_DIV_STEP;
      end
      ifmt_pkg::ST_DIV_STEP: begin
        if (status.step_last) begin
          state_next = ifmt_pkg::ST_SETUP;
        end else if (status.base10) begin
          state_next = ifmt_pkg::ST_DIV_MUL;
        end
      end
      ifmt_pkg::ST_SETUP: begin
        if (status.has_prefix) begin
          state_next = ifmt_pkg::ST_PREFIX;
        end else if (status.lead_needed) begin
          state_next = ifmt_pkg::ST_LEAD;
        end else begin
          state_next = ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_PREFIX: begin
        if (status.out_free && status.prefix_end) begin
          state_next = status.lead_needed ? ifmt_pkg::ST_LEAD : ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_LEAD: begin
        if (status.out_free && status.pad_last) begin
          state_next = ifmt_pkg::ST_DIGITS;
        end
      end
      ifmt_pkg::ST_DIGITS: begin
        if (status.out_free && status.digit_end) begin
          state_next = status.trail_needed ? ifmt_pkg::ST_TRAIL : ifmt_pkg::ST_IDLE;
        end
      end
      ifmt_pkg::ST_TRAIL: begin
        if (status.out_free && status.pad_last) begin
          state_next = ifmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ifmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    cmd.sel  = ifmt_pkg::SEL_PREFIX;
    case (state)
      ifmt_pkg::ST_IDLE: begin
        s_tready = !rst;
        cmd.load = !rst && s_tvalid && status.in_ok;
      end
      ifmt_pkg::ST_DIV_MUL: begin
        cmd.mul = 1'b1;
      end
      ifmt_pkg::ST_DIV_STEP: begin
        cmd.step = 1'b1;
      end
      ifmt_pkg::ST_PREFIX: begin
        cmd.sel  = ifmt_pkg::SEL_PREFIX;
        cmd.push = status.out_free;
      end
      ifmt_pkg::ST_LEAD: begin
        cmd.sel  = ifmt_pkg::SEL_LEAD;
        cmd.push = status.out_free;
      end
      ifmt_pkg::ST_DIGITS: begin
        cmd.sel  = ifmt_pkg::SEL_DIGIT;
        cmd.push = status.out_free;
      end
      ifmt_pkg::ST_TRAIL: begin
        cmd.sel  = ifmt_pkg::SEL_TRAIL;
        cmd.push = status.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ src/ifmt_dpath.sv @@
// ----------------------------------------------------------------------------
// ifmt_dpath
// Datapath: operand decode, digit extraction, digit store and output register.
// ----------------------------------------------------------------------------
module ifmt_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [39:0]            s_tdata,
  input  logic [2:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  input  ifmt_pkg::ctrl_cmd_t    cmd,
  output ifmt_pkg::ctrl_status_t status
);

  logic [31:0] in_value;
  logic [5:0]  in_width;
  logic        in_zpad;
  logic        in_left;
  logic [5:0]  in_wsat;
  logic [5:0]  in_wneg;
  logic        in_ok;
  logic        in_base10;

  ifmt_pkg::base_t load_base;
  logic            load_upper;
  logic            load_neg;
  logic            load_ptr;
  logic            load_zpad;
  logic            load_left;
  logic [5:0]      load_weff;
  logic [31:0]     load_mag;

  logic [31:0] quotient;
  logic [28:0] prod_hi;
  logic [3:0]  digit_store [ifmt_pkg::DIGIT_DEPTH];
  logic [3:0]  digit_count;
  logic [3:0]  digit_idx;
  logic [5:0]  pad_count;
  logic        prefix_idx;
  ifmt_pkg::base_t base;
  logic        upper;
  logic        neg;
  logic        ptr;
  logic        zpad;
  logic        left;
  logic [5:0]  weff;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  logic [63:0] product;
  logic [31:0] q_next;
  logic [31:0] q_times_ten;
  logic [31:0] rem_full;
  logic [3:0]  digit_new;
  logic [3:0]  len_next;
  logic [5:0]  pad_new;
  logic [7:0]  emit_char;
  logic        emit_last;

  assign in_value = s_tdata[31:0];
  assign in_width = s_tdata[37:32];
  assign in_zpad  = s_tdata[38];
  assign in_left  = s_tdata[39];
  assign in_wsat  = (in_width > 6'(ifmt_pkg::WIDTH_MAX)) ? 6'(ifmt_pkg::WIDTH_MAX) : in_width;
  assign in_wneg  = (in_wsat > 6'd1) ? in_wsat - 6'd1 : 6'd0;

  always_comb begin
    in_ok      = 1'b1;
    in_base10  = 1'b0;
    load_base  = ifmt_pkg::BASE_16;
    load_upper = 1'b0;
    load_neg   = 1'b0;
    load_ptr   = 1'b0;
    load_zpad  = in_zpad;
    load_left  = in_left;
    load_weff  = in_wsat;
    load_mag   = in_value;
    case (ifmt_pkg::cmd_t'(s_tuser))
      ifmt_pkg::CMD_SDEC: begin
        in_base10 = 1'b1;
        load_base = ifmt_pkg::BASE_10;
        load_neg  = in_value[31];
        if (in_value[31]) begin
          load_mag  = 32'd0 - in_value;
          load_weff = in_wneg;
        end
      end
      ifmt_pkg::CMD_UDEC: begin
        in_base10 = 1'b1;
        load_base = ifmt_pkg::BASE_10;
      end
      ifmt_pkg::CMD_HEXL: begin
        load_base = ifmt_pkg::BASE_16;
      end
      ifmt_pkg::CMD_HEXU: begin
        load_base  = ifmt_pkg::BASE_16;
        load_upper = 1'b1;
      end
      ifmt_pkg::CMD_OCT: begin
        load_base = ifmt_pkg::BASE_8;
      end
      ifmt_pkg::CMD_PTR: begin
        load_base = ifmt_pkg::BASE_16;
        load_ptr  = 1'b1;
        load_zpad = 1'b1;
        load_left = 1'b0;
        load_weff = 6'(ifmt_pkg::PTR_DIGITS);
      end
      default: begin
        in_ok = 1'b0;
      end
    endcase
  end

  assign product     = {32'd0, quotient} * {32'd0, ifmt_pkg::RECIP_TEN};
  assign q_times_ten = (q_next << 3) + (q_next << 1);
  assign rem_full    = quotient - q_times_ten;

  always_comb begin
    case (base)
      ifmt_pkg::BASE_8: begin
        q_next    = quotient >> 3;
        digit_new = {1'b0, quotient[2:0]};
      end
      ifmt_pkg::BASE_10: begin
        q_next    = {3'd0, prod_hi};
        digit_new = rem_full[3:0];
      end
      default: begin
        q_next    = quotient >> 4;
        digit_new = quotient[3:0];
      end
    endcase
  end

  assign len_next = digit_count + 4'd1;
  assign pad_new  = (weff > {2'd0, len_next}) ? weff - {2'd0, len_next} : 6'd0;

  always_comb begin
    emit_char = ifmt_pkg::CH_SPACE;
    emit_last = 1'b0;
    case (cmd.sel)
      ifmt_pkg::SEL_PREFIX: begin
        if (neg) begin
          emit_char = ifmt_pkg::CH_MINUS;
        end else begin
          emit_char = prefix_idx ? ifmt_pkg::CH_X : ifmt_pkg::CH_ZERO;
        end
      end
      ifmt_pkg::SEL_LEAD: begin
        emit_char = zpad ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
      end
      ifmt_pkg::SEL_DIGIT: begin
        emit_char = ifmt_pkg::digit_char(digit_store[digit_idx], upper);
        emit_last = (digit_idx == 4'd0) && !(left && (pad_count != 6'd0));
      end
      ifmt_pkg::SEL_TRAIL: begin
        emit_char = ifmt_pkg::CH_SPACE;
        emit_last = (pad_count == 6'd1);
      end
      default: begin
        emit_char = ifmt_pkg::CH_SPACE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quotient    <= load_mag;
      digit_count <= 4'd0;
      prefix_idx  <= 1'b0;
      base        <= load_base;
      upper       <= load_upper;
      neg         <= load_neg;
      ptr         <= load_ptr;
      zpad        <= load_zpad;
      left        <= load_left;
      weff        <= load_weff;
    end
    if (cmd.mul) begin
      prod_hi <= product[63:35];
    end
    if (cmd.step) begin
      digit_store[digit_count] <= digit_new;
      quotient    <= q_next;
      digit_count <= len_next;
      digit_idx   <= digit_count;
      pad_count   <= pad_new;
    end
    if (cmd.push) begin
      case (cmd.sel)
        ifmt_pkg::SEL_PREFIX: prefix_idx <= 1'b1;
        ifmt_pkg::SEL_DIGIT:  digit_idx  <= digit_idx - 4'd1;
        default:              pad_count  <= pad_count - 6'd1;
      endcase
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tlast  = out_last;

  always_comb begin
    status.in_ok        = in_ok;
    status.in_base10    = in_base10;
    status.base10       = (base == ifmt_pkg::BASE_10);
    status.step_last    = (q_next == 32'd0) || (len_next == 4'(ifmt_pkg::DIGIT_DEPTH));
    status.has_prefix   = neg || ptr;
    status.prefix_end   = neg || prefix_idx;
    status.lead_needed  = !left && (pad_count != 6'd0);
    status.trail_needed = left && (pad_count != 6'd0);
    status.pad_last     = (pad_count == 6'd1);
    status.digit_end    = (digit_idx == 4'd0);
    status.out_free     = !out_valid || m_tready;
  end

endmodule

@@ src/integer_field_formatter_core.sv @@
// ----------------------------------------------------------------------------
// integer_field_formatter_core
// Formats one 32-bit value as a field of ASCII characters.
// ----------------------------------------------------------------------------
// Each input transaction carries the format kind in s_tuser and the value,
// field width and the two padding flags in s_tdata. The block answers with
// one output transaction per character on the m_ channel, most significant
// digit first, with m_tlast set on the final character of the field. Kinds
// 6 and 7 are accepted and produce no characters.
// The block accepts the transaction, then extracts the digits with one step
// per octal or hex digit and a reciprocal multiply followed by a correction
// step per decimal digit, then runs a setup step. After that one character
// leaves per cycle while the receiver keeps m_tready high. s_tready is high
// only while the controller is idle, which happens as soon as the final
// character has been loaded into the output register.
// When the receiver stalls, the output register holds its character and the
// controller waits in place. Reset clears the controller state and the output
// valid flag; no characters are lost or repeated across a stall.
// ----------------------------------------------------------------------------
module integer_field_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], width[37:32], zero_fill[38], left_just[39]
  input  logic [2:0]  s_tuser,   // command[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // character[7:0]
  output logic        m_tlast
);

  ifmt_pkg::ctrl_cmd_t    cmd;
  ifmt_pkg::ctrl_status_t status;
  ifmt_pkg::state_t       state;

  ifmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  ifmt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!m_tvalid || m_tready))
    else $error("character loaded while the output register was still occupied");

  a_out_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output transaction changed while the receiver stalled");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ifmt_pkg::ST_DIV_MUL || state == ifmt_pkg::ST_DIV_STEP))
    else $error("controller did not start digit extraction after a transaction");

endmodule
